// File: rtl/ssb_pkg.sv
// Shared types and constants for the scaled sprite blitter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ssb_pkg;

    localparam int COLOR_W    = 16;
    localparam int CNT_W      = 9;
    localparam int SIZE_W     = 10;
    localparam int ORG_W      = 11;
    localparam int SCALE_W    = 4;
    localparam int STRIDE_W   = 11;
    localparam int SUB_W      = 3;
    localparam int FY_W       = 15;
    localparam int LIN_W      = FY_W + STRIDE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic setup_a;
        logic setup_b;
        logic step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic blank;
        logic last_step;
        logic cand_ok;
        logic pending_valid;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/ssb_ctrl.sv
// Controller of the scaled sprite blitter: sequences setup, write issue and flush.
// Depends on ssb_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module ssb_ctrl
    import ssb_pkg::*;
(
    input  wire     aclk,
    input  wire     aresetn,
    input  wire     in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A kept write can only leave the holding register when the output word is free.
    assign stall = status.cand_ok && status.pending_valid && !status.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // The input is held off during reset so that no word is taken and lost.
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    cmd.load = 1'b1;
                    if (!status.blank) begin
                        state_next = ST_SETUP_A;
                    end
                end
            end
            ST_SETUP_A: begin
                cmd.setup_a = 1'b1;
                state_next  = ST_SETUP_B;
            end
            ST_SETUP_B: begin
                cmd.setup_b = 1'b1;
                state_next  = ST_RUN;
            end
            ST_RUN: begin
                if (!stall) begin
                    cmd.step = 1'b1;
                    if (status.last_step) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.pending_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.cand_ok && status.pending_valid) |-> status.out_free)
        else $error("kept write pushed into an occupied output word");

    a_last_step_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.last_step) |=> (state_reg == ST_FLUSH))
        else $error("last sub-pixel step not followed by flush");

endmodule

`default_nettype wire

// File: rtl/ssb_datapath.sv
// Datapath of the scaled sprite blitter: registers, source counters, address
// arithmetic, holding register for run_last lookahead and output word. Uses ssb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssb_datapath
    import ssb_pkg::*;
#(
    parameter int ADDR_BITS = 17,
    parameter int MAX_SCALE = 8
) (
    input  wire                                             aclk,
    input  wire                                             aresetn,
    input  wire                                             cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]                            cfg_addr,
    input  wire  [CFG_DATA_W-1:0]                           cfg_wdata,
    input  wire  [COLOR_W-1:0]                              s_tdata,
    input  cmd_t                                            cmd,
    output status_t                                         status,
    input  wire                                             m_tready,
    output logic                                            m_tvalid,
    output logic [((ADDR_BITS + COLOR_W + 7) / 8) * 8-1:0]  m_tdata,
    output logic                                            m_tlast,
    output logic                                            m_tuser
);

    localparam int TDATA_W = ((ADDR_BITS + COLOR_W + 7) / 8) * 8;

    // Configuration registers.
    logic [ORG_W-1:0]    origin_x_reg;
    logic [ORG_W-1:0]    origin_y_reg;
    logic [SIZE_W-1:0]   sprite_width_reg;
    logic [SIZE_W-1:0]   sprite_height_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [STRIDE_W-1:0] row_stride_reg;

    // Source position.
    logic [CNT_W-1:0]    source_column_reg;
    logic [CNT_W-1:0]    source_row_reg;
    logic [CNT_W-1:0]    col_lat_reg;
    logic [CNT_W-1:0]    row_lat_reg;
    logic [COLOR_W-1:0]  pixel_reg;
    logic                done_reg;

    // Address generation.
    logic [FY_W-1:0]         fy0_reg;
    logic [FY_W-1:0]         fx0_reg;
    logic [FY_W-1:0]         fx_reg;
    logic signed [LIN_W-1:0] rowbase_reg;
    logic [SUB_W-1:0]        sub_j_reg;
    logic [SUB_W-1:0]        sub_k_reg;
    logic [ADDR_BITS-1:0]    pend_addr_reg;
    logic                    pending_valid_reg;

    // Output word.
    logic                 m_valid_reg;
    logic [ADDR_BITS-1:0] m_addr_reg;
    logic [COLOR_W-1:0]   m_color_reg;
    logic                 m_last_reg;
    logic                 m_done_reg;

    logic [SCALE_W-1:0]       s_eff;
    logic [CNT_W-1:0]         w_m1;
    logic [CNT_W-1:0]         h_m1;
    logic                     last_col;
    logic                     last_row;
    logic [CNT_W+SCALE_W-1:0] row_scaled;
    logic [CNT_W+SCALE_W-1:0] col_scaled;
    logic [FY_W-1:0]          fy0_next;
    logic [FY_W-1:0]          fx0_next;
    logic signed [LIN_W-1:0]  row_prod;
    logic signed [LIN_W-1:0]  cand;
    logic                     cand_ok;
    logic                     j_end;
    logic                     k_end;
    logic                     out_free;
    logic                     push;

    assign s_eff = (scale_reg > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_reg;

    always_comb begin
        if (sprite_width_reg <= SIZE_W'(1)) begin
            w_m1 = '0;
        end else if (sprite_width_reg > SIZE_W'(512)) begin
            w_m1 = '1;
        end else begin
            w_m1 = CNT_W'(sprite_width_reg - SIZE_W'(1));
        end
        if (sprite_height_reg <= SIZE_W'(1)) begin
            h_m1 = '0;
        end else if (sprite_height_reg > SIZE_W'(512)) begin
            h_m1 = '1;
        end else begin
            h_m1 = CNT_W'(sprite_height_reg - SIZE_W'(1));
        end
    end

    assign last_col = source_column_reg >= w_m1;
    assign last_row = source_row_reg >= h_m1;

    assign row_scaled = {{SCALE_W{1'b0}}, row_lat_reg} * {{CNT_W{1'b0}}, s_eff};
    assign col_scaled = {{SCALE_W{1'b0}}, col_lat_reg} * {{CNT_W{1'b0}}, s_eff};
    assign fy0_next = {{(FY_W-ORG_W){origin_y_reg[ORG_W-1]}}, origin_y_reg}
                    + FY_W'(row_scaled);
    assign fx0_next = {{(FY_W-ORG_W){origin_x_reg[ORG_W-1]}}, origin_x_reg}
                    + FY_W'(col_scaled);
    assign row_prod = $signed({{(LIN_W-FY_W){fy0_reg[FY_W-1]}}, fy0_reg})
                    * $signed({{(LIN_W-STRIDE_W){1'b0}}, row_stride_reg});

    // Linear address of the current sub-pixel and its bounds check.
    assign cand    = rowbase_reg + $signed({{(LIN_W-FY_W){fx_reg[FY_W-1]}}, fx_reg});
    assign cand_ok = !cand[LIN_W-1] && (cand[LIN_W-2:ADDR_BITS] == '0);

    assign j_end = {1'b0, sub_j_reg} == (s_eff - SCALE_W'(1));
    assign k_end = {1'b0, sub_k_reg} == (s_eff - SCALE_W'(1));

    assign out_free = !m_valid_reg || m_tready;
    // A held write goes out once a later kept write exists, or at flush with run_last.
    assign push = (cmd.step && cand_ok && pending_valid_reg) || cmd.flush;

    assign status.blank         = (s_tdata == '0) || (s_eff == '0);
    assign status.last_step     = j_end && k_end;
    assign status.cand_ok       = cand_ok;
    assign status.pending_valid = pending_valid_reg;
    assign status.out_free      = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            sprite_width_reg  <= SIZE_W'(1);
            sprite_height_reg <= SIZE_W'(1);
            scale_reg         <= SCALE_W'(1);
            row_stride_reg    <= STRIDE_W'(320);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ORIGIN_X:      origin_x_reg      <= cfg_wdata[ORG_W-1:0];
                REG_ORIGIN_Y:      origin_y_reg      <= cfg_wdata[ORG_W-1:0];
                REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_SCALE:         scale_reg         <= cfg_wdata[SCALE_W-1:0];
                REG_ROW_STRIDE:    row_stride_reg    <= cfg_wdata[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_column_reg <= '0;
            source_row_reg    <= '0;
        end else if (cmd.load) begin
            if (last_col) begin
                source_column_reg <= '0;
                source_row_reg    <= last_row ? '0 : source_row_reg + CNT_W'(1);
            end else begin
                source_column_reg <= source_column_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_lat_reg <= source_column_reg;
            row_lat_reg <= source_row_reg;
            pixel_reg   <= s_tdata;
            done_reg    <= last_col && last_row;
        end
        if (cmd.setup_a) begin
            fy0_reg <= fy0_next;
            fx0_reg <= fx0_next;
        end
        if (cmd.setup_b) begin
            rowbase_reg <= row_prod;
            fx_reg      <= fx0_reg;
            sub_j_reg   <= '0;
            sub_k_reg   <= '0;
        end else if (cmd.step) begin
            if (j_end) begin
                sub_j_reg   <= '0;
                sub_k_reg   <= sub_k_reg + SUB_W'(1);
                fx_reg      <= fx0_reg;
                rowbase_reg <= rowbase_reg + $signed({{(LIN_W-STRIDE_W){1'b0}}, row_stride_reg});
            end else begin
                sub_j_reg <= sub_j_reg + SUB_W'(1);
                fx_reg    <= fx_reg + FY_W'(1);
            end
            if (cand_ok) begin
                pend_addr_reg <= cand[ADDR_BITS-1:0];
            end
        end
        if (push) begin
            m_addr_reg  <= pend_addr_reg;
            m_color_reg <= pixel_reg;
            m_last_reg  <= cmd.flush;
            m_done_reg  <= done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_valid_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cmd.setup_b || cmd.flush) begin
                pending_valid_reg <= 1'b0;
            end else if (cmd.step && cand_ok) begin
                pending_valid_reg <= 1'b1;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({m_color_reg, m_addr_reg});
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

    // After the last step the sub-row index has moved one past the block while
    // the final write waits for flush.
    a_sub_index_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_valid_reg |-> ({1'b0, sub_j_reg} < s_eff && {1'b0, sub_k_reg} <= s_eff))
        else $error("sub-pixel index outside the scale block");

endmodule

`default_nettype wire

// File: rtl/scaled_sprite_blit_unit.sv
// Scaled sprite blitter with colour-key transparency: top level.
// Instantiates ssb_ctrl and ssb_datapath; uses ssb_pkg.
//
// Source pixels enter one word at a time in raster order; every non-zero
// pixel is replicated into a scale x scale block of framebuffer writes,
// sub-rows outermost, and writes whose linear address falls outside the
// framebuffer are dropped. ST_IDLE takes each word, making no write for a
// transparent one. For a coloured one ST_SETUP_A and ST_SETUP_B form the
// block origin and row base address (registered multiplies), ST_RUN steps
// the sub-pixels through the single address adder and bounds check, stalling
// while a held write must move into a busy output word, and ST_FLUSH releases
// the final write with tlast. Each kept write is held until the next kept
// write or the flush, so tlast can mark the last even when later sub-pixels
// are clipped. The user writes registers only while the block is idle; unenforced.
`timescale 1ns / 1ps
`default_nettype none

module scaled_sprite_blit_unit
    import ssb_pkg::*;
#(
    parameter int ADDR_BITS = 17,
    parameter int MAX_SCALE = 8
) (
    input  wire                                             aclk,
    input  wire                                             aresetn,
    input  wire                                             cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]                            cfg_addr,
    input  wire  [CFG_DATA_W-1:0]                           cfg_wdata,
    input  wire                                             s_tvalid,
    output logic                                            s_tready,
    input  wire  [COLOR_W-1:0]                              s_tdata,  // pixel_value
    output logic                                            m_tvalid,
    input  wire                                             m_tready,
    // write_address, then write_color, zero padded to whole bytes
    output logic [((ADDR_BITS + COLOR_W + 7) / 8) * 8-1:0]  m_tdata,
    output logic                                            m_tlast,  // run_last
    output logic                                            m_tuser   // sprite_done
);

    cmd_t    cmd;
    status_t status;

    ssb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssb_datapath #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
